// ----- hdl/m3i_pkg.sv -----
package m3i_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int THR_W          = 31;
  localparam int NENT           = 9;
  localparam int FIFO_DEPTH     = 2;

  // Each cofactor k is a[CF_P[k]] * a[CF_Q[k]] - a[CF_R[k]] * a[CF_S[k]].
  localparam int CF_P [NENT] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam int CF_Q [NENT] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam int CF_R [NENT] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam int CF_S [NENT] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

  // The determinant expands along row 0: a0*c0 + a1*c3 + a2*c6.
  localparam int DET_C [3] = '{0, 3, 6};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } m3i_state_e;

endpackage

// ----- hdl/m3i_if.sv -----
interface m3i_mat_if #(parameter int W = m3i_pkg::DATA_WIDTH_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                 input ready);
  modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
               output ready);
endinterface

interface m3i_res_if #(parameter int W = m3i_pkg::DATA_WIDTH_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  logic [W-1:0] determinant;
  logic         singular;
  modport source(output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20,
                 inv21, inv22, determinant, singular, input ready);
  modport sink(input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20,
               inv21, inv22, determinant, singular, output ready);
endinterface

interface m3i_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [m3i_pkg::THR_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- hdl/m3i_front.sv -----
module m3i_front #(
  parameter int W = m3i_pkg::DATA_WIDTH_DEF,
  parameter int F = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  m3i_mat_if.sink                             in_i,
  m3i_cfg_if.sink                             cfg_i,
  output logic                                item_valid_o,
  input  logic                                item_ready_i,
  output logic [m3i_pkg::NENT-1:0][2*W-1:0]   cmag_o,
  output logic [m3i_pkg::NENT-1:0]            cneg_o,
  output logic [3*W-1:0]                      dmag_o,
  output logic                                dneg_o,
  output logic [W-1:0]                        dout_o,
  output logic                                sing_o
);
  import m3i_pkg::*;

  localparam int DW = 3 * W + 2;
  localparam int XW = W + THR_W;

  logic [THR_W-1:0] thr_q;
  logic [7:1]       v_q;
  logic             en;

  logic signed [W-1:0]   a_in [NENT];
  logic signed [W-1:0]   a_q [NENT];
  logic signed [2*W-1:0] pq_q [NENT];
  logic signed [2*W-1:0] rs_q [NENT];
  logic [W-1:0]          am2_q [3];
  logic [2:0]            an2_q;
  logic signed [2*W:0]   cof3_q [NENT];
  logic [W-1:0]          am3_q [3];
  logic [2:0]            an3_q;
  logic [2*W-1:0]        cm4_q [NENT];
  logic [NENT-1:0]       cn4_q;
  logic [W-1:0]          am4_q [3];
  logic [2:0]            an4_q;
  logic [2*W-1:0]        plo5_q [3];
  logic [2*W-1:0]        phi5_q [3];
  logic [2:0]            tn5_q;
  logic [2*W-1:0]        cm5_q [NENT];
  logic [NENT-1:0]       cn5_q;
  logic [DW-1:0]         det6_q;
  logic [2*W-1:0]        cm6_q [NENT];
  logic [NENT-1:0]       cn6_q;

  logic [DW-1:0]  term [3];
  logic [DW-1:0]  det_sum;
  logic           dneg_c;
  logic [3*W-1:0] dmag_c;
  logic [3*W:0]   rnd_c;
  logic [W-1:0]   lim_c;
  logic [W-1:0]   dabs_c;

  assign en        = !v_q[7] || item_ready_i;
  assign in_i.ready = en;
  assign cfg_i.ready = 1'b1;
  assign item_valid_o = v_q[7];

  assign a_in[0] = in_i.a00;
  assign a_in[1] = in_i.a01;
  assign a_in[2] = in_i.a02;
  assign a_in[3] = in_i.a10;
  assign a_in[4] = in_i.a11;
  assign a_in[5] = in_i.a12;
  assign a_in[6] = in_i.a20;
  assign a_in[7] = in_i.a21;
  assign a_in[8] = in_i.a22;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      v_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        thr_q <= cfg_i.data;
      end
      if (en) begin
        v_q <= {v_q[6:1], in_i.valid};
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      term[j] = DW'({phi5_q[j], {W{1'b0}}}) + DW'(plo5_q[j]);
      if (tn5_q[j]) begin
        term[j] = -term[j];
      end
    end
    det_sum = term[0] + term[1] + term[2];
  end

  always_comb begin
    dneg_c = det6_q[DW-1];
    dmag_c = dneg_c ? (3*W)'(-det6_q) : (3*W)'(det6_q);
    rnd_c  = (3*W+1)'(dmag_c >> (2 * F)) + (3*W+1)'(dmag_c[2*F-1]);
    lim_c  = {dneg_c, {(W-1){!dneg_c}}};
    dabs_c = (rnd_c > (3*W+1)'(lim_c)) ? lim_c : W'(rnd_c);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NENT; i++) begin
        a_q[i]   <= a_in[i];
        pq_q[i]  <= a_q[CF_P[i]] * a_q[CF_Q[i]];
        rs_q[i]  <= a_q[CF_R[i]] * a_q[CF_S[i]];
        cof3_q[i] <= (2*W+1)'(pq_q[i]) - (2*W+1)'(rs_q[i]);
        cn4_q[i] <= cof3_q[i][2*W];
        cm4_q[i] <= cof3_q[i][2*W] ? (2*W)'(-cof3_q[i]) : (2*W)'(cof3_q[i]);
        cm5_q[i] <= cm4_q[i];
        cn5_q[i] <= cn4_q[i];
        cm6_q[i] <= cm5_q[i];
        cn6_q[i] <= cn5_q[i];
        cmag_o[i] <= cm6_q[i];
        cneg_o[i] <= cn6_q[i];
      end
      for (int j = 0; j < 3; j++) begin
        an2_q[j]  <= a_q[j][W-1];
        am2_q[j]  <= a_q[j][W-1] ? W'(-a_q[j]) : W'(a_q[j]);
        am3_q[j]  <= am2_q[j];
        an3_q[j]  <= an2_q[j];
        am4_q[j]  <= am3_q[j];
        an4_q[j]  <= an3_q[j];
        plo5_q[j] <= (2*W)'(am4_q[j]) * (2*W)'(cm4_q[DET_C[j]][W-1:0]);
        phi5_q[j] <= (2*W)'(am4_q[j]) * (2*W)'(cm4_q[DET_C[j]][2*W-1:W]);
        tn5_q[j]  <= an4_q[j] ^ cn4_q[DET_C[j]];
      end
      det6_q <= det_sum;
      dmag_o <= dmag_c;
      dneg_o <= dneg_c;
      dout_o <= dneg_c ? -dabs_c : dabs_c;
      sing_o <= XW'(dabs_c) <= XW'(thr_q);
    end
  end

endmodule

// ----- hdl/m3i_fifo.sv -----
module m3i_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);
  import m3i_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [FIFO_DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      cnt_q;
  logic             push, pop;

  assign wr_ready_o = cnt_q != (PW+1)'(FIFO_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- hdl/m3i_back.sv -----
module m3i_back #(
  parameter int W = m3i_pkg::DATA_WIDTH_DEF,
  parameter int F = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  output logic                              item_ready_o,
  input  logic [m3i_pkg::NENT-1:0][2*W-1:0] cmag_i,
  input  logic [m3i_pkg::NENT-1:0]          cneg_i,
  input  logic [3*W-1:0]                    dmag_i,
  input  logic                              dneg_i,
  input  logic [W-1:0]                      dout_i,
  input  logic                              sing_i,
  m3i_res_if.source                         out_o
);
  import m3i_pkg::*;

  localparam int RW  = 2 * W + 2 * F + 1;
  localparam int SW  = (4 * W + 2 > RW) ? 4 * W + 2 : RW;
  localparam int QW  = W + 2;
  localparam int CNW = $clog2(QW);

  m3i_state_e      state_q, state_d;
  logic [SW-1:0]   rem_q [NENT];
  logic [QW-1:0]   quot_q [NENT];
  logic [NENT-1:0] cneg_q;
  logic [SW-1:0]   ds_q;
  logic [3*W-1:0]  dmag_q;
  logic            dneg_q;
  logic [W-1:0]    dout_q;
  logic            sing_q;
  logic [CNW-1:0]  cnt_q;

  logic            pop, load_out, step;
  logic [W-1:0]    res_c [NENT];
  logic [W-1:0]    res_q [NENT];
  logic            out_valid_q;
  logic [W-1:0]    odet_q;
  logic            osing_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = sing_i ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q == CNW'(QW - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready_o = 1'b0;
    step         = 1'b0;
    load_out     = 1'b0;
    case (state_q)
      ST_IDLE: item_ready_o = 1'b1;
      ST_RUN:  step         = 1'b1;
      ST_FIN:  load_out     = !out_valid_q || out_o.ready;
      default: item_ready_o = 1'b0;
    endcase
  end

  assign pop = item_valid_i && item_ready_o;

  always_comb begin
    logic [SW:0]   twice;
    logic          rnd;
    logic [QW-1:0] q;
    logic [W-1:0]  lim;
    logic [W-1:0]  mag;
    logic          neg;
    for (int i = 0; i < NENT; i++) begin
      twice = {rem_q[i], 1'b0};
      rnd   = twice >= (SW+1)'(dmag_q);
      q     = {1'b0, quot_q[i][QW-2:0]} + QW'(rnd);
      neg   = cneg_q[i] != dneg_q;
      lim   = {neg, {(W-1){!neg}}};
      mag   = (quot_q[i][QW-1] || q > QW'(lim)) ? lim : W'(q);
      res_c[i] = sing_q ? '0 : (neg ? -mag : mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        cnt_q <= '0;
      end else if (step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ds_q   <= SW'(dmag_i) << (W + 1);
      dmag_q <= dmag_i;
      dneg_q <= dneg_i;
      dout_q <= dout_i;
      sing_q <= sing_i;
      for (int i = 0; i < NENT; i++) begin
        rem_q[i]  <= SW'(cmag_i[i]) << (2 * F);
        quot_q[i] <= '0;
        cneg_q[i] <= cneg_i[i];
      end
    end else if (step) begin
      ds_q <= ds_q >> 1;
      for (int i = 0; i < NENT; i++) begin
        if (rem_q[i] >= ds_q) begin
          rem_q[i] <= rem_q[i] - ds_q;
        end
        quot_q[i] <= {quot_q[i][QW-2:0], rem_q[i] >= ds_q};
      end
    end
    if (load_out) begin
      res_q   <= res_c;
      odet_q  <= dout_q;
      osing_q <= sing_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.inv00       = res_q[0];
  assign out_o.inv01       = res_q[1];
  assign out_o.inv02       = res_q[2];
  assign out_o.inv10       = res_q[3];
  assign out_o.inv11       = res_q[4];
  assign out_o.inv12       = res_q[5];
  assign out_o.inv20       = res_q[6];
  assign out_o.inv21       = res_q[7];
  assign out_o.inv22       = res_q[8];
  assign out_o.determinant = odet_q;
  assign out_o.singular    = osing_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> state_q == ST_IDLE)
    else $error("item taken while the divider is busy");

  a_sing_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && sing_i |=> state_q == ST_FIN)
    else $error("singular item entered the divider");

  a_load_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> state_q == ST_FIN)
    else $error("result loaded outside the finish step");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && osing_q |-> res_q[0] == '0 && res_q[4] == '0 && res_q[8] == '0)
    else $error("singular result carries a nonzero inverse");

endmodule

// ----- hdl/matrix3x3_inverse.sv -----
// 3x3 matrix inverse by the adjugate in signed fixed point (DATA_WIDTH bits,
// FRAC_BITS fractional). A seven-stage front pipeline takes one matrix per cycle
// unless the full queue holds it back, forms the nine cofactors and the exact
// determinant, rounds and saturates the determinant and flags the matrix as
// singular when its magnitude is at or below the threshold register. A two-entry
// queue feeds the back end, which runs nine restoring dividers in parallel, one
// quotient bit per cycle, for each regular matrix and skips them for a singular
// one, whose inverse is returned as zero; it takes a new matrix only once it is done
// with the last, so that divider loop sets the sustained rate. The threshold may be
// written only while the block is idle.
module matrix3x3_inverse #(
  parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  m3i_mat_if.sink   in_i,
  m3i_cfg_if.sink   cfg_i,
  m3i_res_if.source out_o
);
  import m3i_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int IW = NENT * 2 * W + NENT + 3 * W + 1 + W + 1;

  logic                      f_valid, f_ready, b_valid, b_ready;
  logic [NENT-1:0][2*W-1:0]  f_cmag, b_cmag;
  logic [NENT-1:0]           f_cneg, b_cneg;
  logic [3*W-1:0]            f_dmag, b_dmag;
  logic                      f_dneg, b_dneg;
  logic [W-1:0]              f_dout, b_dout;
  logic                      f_sing, b_sing;
  logic [IW-1:0]             f_word, b_word;

  m3i_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .cmag_o       (f_cmag),
    .cneg_o       (f_cneg),
    .dmag_o       (f_dmag),
    .dneg_o       (f_dneg),
    .dout_o       (f_dout),
    .sing_o       (f_sing)
  );

  assign f_word = {f_cmag, f_cneg, f_dmag, f_dneg, f_dout, f_sing};

  m3i_fifo #(.WIDTH(IW)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_word),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_word)
  );

  assign {b_cmag, b_cneg, b_dmag, b_dneg, b_dout, b_sing} = b_word;

  m3i_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .cmag_i       (b_cmag),
    .cneg_i       (b_cneg),
    .dmag_i       (b_dmag),
    .dneg_i       (b_dneg),
    .dout_i       (b_dout),
    .sing_i       (b_sing),
    .out_o        (out_o)
  );

endmodule

// ----- tb/matrix3x3_inverse_test.sv -----
`timescale 1ns / 1ps

module matrix3x3_inverse_test;
  import m3i_pkg::*;

  typedef logic [8:0][31:0] matrix_t;

  typedef struct {
    matrix_t     inv;
    logic [31:0] det;
    logic        sing;
  } inverse_t;

  class InverseScoreboard;
    inverse_t    pending_inverses[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic [31:0] clamp(logic [191:0] mag, bit neg, output logic [31:0] absv);
      logic [191:0] lim;
      lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
      if (mag > lim) mag = lim;
      absv = mag[31:0];
      return neg ? (32'd0 - mag[31:0]) : mag[31:0];
    endfunction

    function inverse_t invert_matrix(matrix_t m, logic [THR_W-1:0] thr);
      logic signed [191:0] a[9];
      logic signed [191:0] cof[9];
      logic signed [191:0] det;
      logic [191:0]        det_mag, rounded, num, quo, rem;
      logic [31:0]         dabs, junk;
      inverse_t            r;
      for (int i = 0; i < 9; i++) a[i] = {{160{m[i][31]}}, m[i]};
      cof[0] = a[4] * a[8] - a[7] * a[5];
      cof[1] = a[2] * a[7] - a[1] * a[8];
      cof[2] = a[1] * a[5] - a[2] * a[4];
      cof[3] = a[5] * a[6] - a[3] * a[8];
      cof[4] = a[0] * a[8] - a[2] * a[6];
      cof[5] = a[3] * a[2] - a[0] * a[5];
      cof[6] = a[3] * a[7] - a[6] * a[4];
      cof[7] = a[6] * a[1] - a[0] * a[7];
      cof[8] = a[0] * a[4] - a[3] * a[1];
      det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
      det_mag = det < 0 ? -det : det;
      rounded = (det_mag >> 32) + det_mag[31];
      r.det = clamp(rounded, det < 0 && rounded != 0, dabs);
      r.sing = dabs <= {1'b0, thr};
      for (int i = 0; i < 9; i++) begin
        if (r.sing) begin
          r.inv[i] = '0;
        end else begin
          num = (cof[i] < 0 ? -cof[i] : cof[i]) << 32;
          quo = num / det_mag;
          rem = num % det_mag;
          if ((rem << 1) >= det_mag) quo = quo + 1;
          r.inv[i] = clamp(quo, ((cof[i] < 0) != (det < 0)) && quo != 0, junk);
        end
      end
      return r;
    endfunction

    function void note_matrix(matrix_t m, logic [THR_W-1:0] thr);
      pending_inverses.insert(pending_inverses.size(), invert_matrix(m, thr));
    endfunction

    function void check_inverse(inverse_t got);
      inverse_t want;
      bit       bad;
      if (pending_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $time);
        return;
      end
      want = pending_inverses[0];
      pending_inverses.delete(0);
      bad = 0;
      for (int i = 0; i < 9; i++) begin
        if (got.inv[i] !== want.inv[i]) begin
          bad = 1;
          if (mismatches < 10)
            $display("inv%0d%0d: expected %h, got %h", i / 3, i % 3, want.inv[i],
                     got.inv[i]);
        end
      end
      if (got.det !== want.det) begin
        bad = 1;
        if (mismatches < 10)
          $display("determinant: expected %h, got %h", want.det, got.det);
      end
      if (got.sing !== want.sing) begin
        bad = 1;
        if (mismatches < 10)
          $display("singular: expected %b, got %b", want.sing, got.sing);
      end
      if (bad) mismatches++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  m3i_mat_if in_if();
  m3i_res_if out_if();
  m3i_cfg_if cfg_if();

  matrix3x3_inverse u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  InverseScoreboard  board = new();
  logic [THR_W-1:0]  threshold;
  int unsigned       beats_out;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  initial begin
    #8ms;
    $display("matrix3x3_inverse_test: FAIL");
    $finish;
  end

  task automatic drive_matrix(matrix_t m);
    in_if.valid <= 1'b1;
    in_if.a00 <= m[0];
    in_if.a01 <= m[1];
    in_if.a02 <= m[2];
    in_if.a10 <= m[3];
    in_if.a11 <= m[4];
    in_if.a12 <= m[5];
    in_if.a20 <= m[6];
    in_if.a21 <= m[7];
    in_if.a22 <= m[8];
    do @(posedge clk_i); while (!in_if.ready);
    board.note_matrix(m, threshold);
    @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    threshold = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (board.pending_inverses.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  function automatic logic [31:0] q16(int v);
    return v <<< 16;
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int      kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 9; i++) begin
      if (kind < 55) m[i] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      else if (kind < 75) m[i] = $urandom;
      else m[i] = $urandom_range(0, 1024) - 512;
    end
    if (kind >= 85) begin
      // A dependent third row, with a little noise to land near singular.
      for (int c = 0; c < 3; c++)
        m[6 + c] = m[c] + m[3 + c] + ($urandom_range(0, 6) - 3);
    end
    return m;
  endfunction

  task automatic send_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < count; i++) begin
        drive_matrix(random_matrix());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic send_directed();
    matrix_t m;
    matrix_t list[$];
    m = '0; m[0] = q16(1); m[4] = q16(1); m[8] = q16(1);
    list.insert(list.size(), m);
    m = '0; m[0] = q16(-1); m[4] = q16(-1); m[8] = q16(-1);
    list.insert(list.size(), m);
    m = '0; m[0] = q16(2); m[4] = q16(4); m[8] = q16(-8);
    list.insert(list.size(), m);
    m = '0; m[1] = q16(1); m[5] = q16(1); m[6] = q16(1);
    list.insert(list.size(), m);
    m = '0; list.insert(list.size(), m);
    for (int i = 0; i < 9; i++) m[i] = 32'h7FFF_FFFF;
    list.insert(list.size(), m);
    for (int i = 0; i < 9; i++) m[i] = 32'h8000_0000;
    list.insert(list.size(), m);
    m = '0; m[0] = 32'h8000_0000; m[4] = 32'h8000_0000; m[8] = 32'h8000_0000;
    list.insert(list.size(), m);
    m = '0; m[0] = 32'h7FFF_FFFF; m[4] = 32'h7FFF_FFFF; m[8] = 32'h7FFF_FFFF;
    list.insert(list.size(), m);
    m = '0; m[0] = 32'h0000_0100; m[4] = 32'h0000_0100; m[8] = 32'h0000_0100;
    list.insert(list.size(), m);
    m = '0; m[0] = 32'h0000_0001; m[4] = q16(1); m[8] = q16(1);
    list.insert(list.size(), m);
    m = '0; m[0] = 32'h0000_8000; m[4] = q16(1); m[8] = 32'h0000_0001;
    list.insert(list.size(), m);
    for (int i = 0; i < 9; i++) m[i] = q16(i + 1);
    list.insert(list.size(), m);
    for (int i = 0; i < 9; i++) m[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    list.insert(list.size(), m);
    m = '0; m[0] = q16(3); m[1] = q16(-2); m[3] = q16(1); m[4] = q16(5);
    m[5] = 32'h0001_8000; m[7] = q16(-7); m[8] = q16(2);
    list.insert(list.size(), m);
    m = '0; m[0] = 32'hFFFF_FFFF; m[4] = 32'hFFFF_FFFF; m[8] = 32'h5555_5555;
    list.insert(list.size(), m);
    foreach (list[i]) drive_matrix(list[i]);
    in_if.valid <= 1'b0;
  endtask

  initial begin
    logic [THR_W-1:0] settings[6];
    rst_ni        = 1'b0;
    threshold     = '0;
    in_if.valid  <= 1'b0;
    in_if.a00 <= '0; in_if.a01 <= '0; in_if.a02 <= '0;
    in_if.a10 <= '0; in_if.a11 <= '0; in_if.a12 <= '0;
    in_if.a20 <= '0; in_if.a21 <= '0; in_if.a22 <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    settings = '{31'd0, 31'h7FFF_FFFF, 31'h0001_0000, 31'd1, 31'h0, 31'h0};
    settings[4] = THR_W'($urandom_range(0, 32'h0010_0000));
    settings[5] = THR_W'($urandom);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_directed();
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_threshold(settings[p]);
      send_random(205);
    end
    wait_idle();
    if (board.mismatches == 0 && board.pending_inverses.size() == 0) begin
      $display("matrix3x3_inverse_test: PASS");
    end else begin
      $display("matrix3x3_inverse_test: FAIL");
    end
    $finish;
  end

  initial begin
    int hold_left;
    int mode_left;
    bit choppy;
    bit held;
    out_if.ready <= 1'b0;
    held      = 0;
    hold_left = 0;
    mode_left = 0;
    choppy    = 0;
    forever begin
      @(negedge clk_i);
      if (!held && beats_out >= 100) begin
        held      = 1;
        hold_left = 600;
      end
      if (mode_left == 0) begin
        choppy    = $urandom_range(0, 1);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
    end
  end

  initial beats_out = 0;

  always @(posedge clk_i) begin
    inverse_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.inv[0] = out_if.inv00;
      got.inv[1] = out_if.inv01;
      got.inv[2] = out_if.inv02;
      got.inv[3] = out_if.inv10;
      got.inv[4] = out_if.inv11;
      got.inv[5] = out_if.inv12;
      got.inv[6] = out_if.inv20;
      got.inv[7] = out_if.inv21;
      got.inv[8] = out_if.inv22;
      got.det    = out_if.determinant;
      got.sing   = out_if.singular;
      board.check_inverse(got);
      beats_out++;
    end
  end

endmodule
